// ===== rtl/word_to_block_gearbox_defines.svh =====
// ----------------------------------------------------------------------------
// word_to_block_gearbox assertion macros
// Shared property wrappers for the gearbox RTL; clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef WORD_TO_BLOCK_GEARBOX_DEFINES_SVH
`define WORD_TO_BLOCK_GEARBOX_DEFINES_SVH

// Same-cycle implication.
`define W2B_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define W2B_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/w2b_pkg.sv =====
// ----------------------------------------------------------------------------
// w2b_pkg
// Widths and shared types of the word-to-block gearbox.
// ----------------------------------------------------------------------------
package w2b_pkg;

    localparam int WORD_BITS = 32;
    localparam int BLK_BITS  = 31;
    localparam int WID_W     = 5;
    localparam int CNT_W     = $clog2(WORD_BITS + 1);
    localparam int SPAN_LVLS = $clog2(WORD_BITS);
    localparam int TDATA_W   = ((BLK_BITS + 7) / 8) * 8;

    localparam logic [WID_W-1:0] BW_RESET = WID_W'(8);

    typedef struct packed {
        logic                valid;
        logic [BLK_BITS-1:0] block;
        logic                last_block;
        logic                empty_res;
    } w2b_res_t;

endpackage

// ===== rtl/w2b_span.sv =====
// ----------------------------------------------------------------------------
// w2b_span
// Significant bit count of a word: index of the highest set bit plus one.
// ----------------------------------------------------------------------------
module w2b_span
    import w2b_pkg::*;
(
    input  logic [WORD_BITS-1:0] data,
    output logic [CNT_W-1:0]     avail
);

    logic [CNT_W-1:0]     n;
    logic [WORD_BITS-1:0] x;

    // binary search for the leading one, one halving per level
    always_comb
    begin
        n = '0;
        x = data;
        for (int k = SPAN_LVLS - 1; k >= 0; k--)
        begin
            if ((x >> (1 << k)) != '0)
            begin
                n = n + CNT_W'(1 << k);
                x = x >> (1 << k);
            end
        end
        avail = (data == '0) ? '0 : n + CNT_W'(1);
    end

endmodule

// ===== rtl/w2b_slicer.sv =====
// ----------------------------------------------------------------------------
// w2b_slicer
// Holds the current word and the carry; cuts one block per step.
// ----------------------------------------------------------------------------
`include "word_to_block_gearbox_defines.svh"

module w2b_slicer
    import w2b_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [WID_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [WORD_BITS-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic [CNT_W-1:0]     in_span,
    input  logic                 out_ready,
    output w2b_res_t             res
);

    logic [WID_W-1:0]     width_reg;
    logic [WORD_BITS-1:0] data_reg, data_next;
    logic [CNT_W-1:0]     avail_reg, avail_next;
    logic                 last_reg;
    logic                 busy_reg, busy_next;
    logic [BLK_BITS-1:0]  carry_bits_reg, carry_bits_next;
    logic [WID_W-1:0]     carry_cnt_reg, carry_cnt_next;
    logic                 first_reg, first_next;

    logic [WID_W-1:0]     w_eff;
    logic [WID_W-1:0]     need;
    logic                 fits;
    logic                 step;
    logic                 done;
    logic                 accept;
    logic [WORD_BITS-1:0] low_part;
    logic [WORD_BITS-1:0] data_sh;
    logic [CNT_W-1:0]     avail_left;
    logic [BLK_BITS-1:0]  blk_full;
    logic [BLK_BITS-1:0]  tail_bits;
    logic [WID_W-1:0]     tail_cnt;

    assign w_eff      = (width_reg == '0) ? WID_W'(1) : width_reg;
    assign need       = w_eff - carry_cnt_reg;
    assign fits       = CNT_W'(need) <= avail_reg;
    assign step       = busy_reg && out_ready;
    assign low_part   = data_reg & ~({WORD_BITS{1'b1}} << need);
    assign data_sh    = data_reg >> need;
    assign avail_left = avail_reg - CNT_W'(need);
    assign blk_full   = carry_bits_reg | BLK_BITS'(low_part << carry_cnt_reg);
    assign tail_bits  = carry_bits_reg | BLK_BITS'(data_reg << carry_cnt_reg);
    assign tail_cnt   = carry_cnt_reg + WID_W'(avail_reg);

    always_comb
    begin
        data_next       = data_reg;
        avail_next      = avail_reg;
        busy_next       = busy_reg;
        carry_bits_next = carry_bits_reg;
        carry_cnt_next  = carry_cnt_reg;
        first_next      = first_reg;
        done            = 1'b0;
        res             = '0;

        if (step)
        begin
            if (fits)
            begin
                // a full block leaves
                res.valid = 1'b1;
                res.block = blk_full;
                data_next = data_sh;
                avail_next = avail_left;
                carry_bits_next = '0;
                carry_cnt_next = '0;
                if (last_reg && avail_left == '0)
                begin
                    res.last_block = 1'b1;
                    done = 1'b1;
                    first_next = 1'b1;
                end
                else if (!last_reg && avail_left < CNT_W'(w_eff))
                begin
                    // leftover goes to the carry, word finished
                    done = 1'b1;
                    first_next = 1'b0;
                    carry_bits_next = BLK_BITS'(data_sh);
                    carry_cnt_next = WID_W'(avail_left);
                end
            end
            else
            begin
                done = 1'b1;
                if (last_reg)
                begin
                    // final short block, or the lone result of an empty top word
                    res.valid = 1'b1;
                    res.block = (tail_cnt != '0) ? tail_bits : '0;
                    res.last_block = 1'b1;
                    res.empty_res = (tail_cnt == '0) && first_reg;
                    carry_bits_next = '0;
                    carry_cnt_next = '0;
                    first_next = 1'b1;
                end
                else
                begin
                    carry_bits_next = tail_bits;
                    carry_cnt_next = tail_cnt;
                    first_next = 1'b0;
                end
            end
            if (done)
            begin
                busy_next = 1'b0;
            end
        end

        if (accept)
        begin
            data_next  = s_tdata;
            avail_next = s_tlast ? in_span : CNT_W'(WORD_BITS);
            busy_next  = 1'b1;
        end
    end

    assign s_tready = !busy_reg || (step && done);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= BW_RESET;
            busy_reg       <= 1'b0;
            carry_bits_reg <= '0;
            carry_cnt_reg  <= '0;
            first_reg      <= 1'b1;
        end
        else if (cfg_wen)
        begin
            // new width abandons any number in flight
            width_reg      <= cfg_wdata;
            busy_reg       <= 1'b0;
            carry_bits_reg <= '0;
            carry_cnt_reg  <= '0;
            first_reg      <= 1'b1;
        end
        else
        begin
            busy_reg       <= busy_next;
            carry_bits_reg <= carry_bits_next;
            carry_cnt_reg  <= carry_cnt_next;
            first_reg      <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        avail_reg <= avail_next;
        if (accept)
        begin
            last_reg <= s_tlast;
        end
    end

    `W2B_ASSERT_IMPL(a_carry_below_width, busy_reg, carry_cnt_reg < w_eff, "carry reached block width")
    `W2B_ASSERT_IMPL(a_empty_is_final, res.valid && res.empty_res, res.last_block, "empty result not final")
    `W2B_ASSERT_NEXT(a_accept_busy, accept && !cfg_wen, busy_reg, "accepted item not held")

endmodule

// ===== rtl/w2b_out_reg.sv =====
// ----------------------------------------------------------------------------
// w2b_out_reg
// Result register toward the master side; frees the slicer from the sink.
// ----------------------------------------------------------------------------
module w2b_out_reg
    import w2b_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  w2b_res_t           res,
    output logic               out_ready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast,
    output logic               m_tuser
);

    logic                valid_reg;
    logic [BLK_BITS-1:0] block_reg;
    logic                last_reg;
    logic                empty_reg;

    assign out_ready = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && res.valid)
        begin
            block_reg <= res.block;
            last_reg  <= res.last_block;
            empty_reg <= res.empty_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = TDATA_W'(block_reg);
    assign m_tlast  = last_reg;
    assign m_tuser  = empty_reg;

endmodule

// ===== rtl/word_to_block_gearbox.sv =====
// ----------------------------------------------------------------------------
// word_to_block_gearbox
// Cuts a multiword number into blocks of a programmable width.
// ----------------------------------------------------------------------------
// Words of the number arrive least significant first, tlast on the top word;
// blocks of block_width bits (1..31, 0 acts as 1) leave least significant
// first, the final one zero-padded and marked by tlast, a zero number as one
// item with tuser set. The slicer emits one block per cycle, when the output
// register can take it, into that register, so a word occupies the slicer
// until all its blocks and any short tail on the top word have been cut;
// the next word is taken in the cycle its predecessor finishes. Writing
// block_width abandons a number in flight; write it only while idle.
module word_to_block_gearbox
    import w2b_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [WID_W-1:0]     cfg_wdata,  // block_width
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [WORD_BITS-1:0] s_tdata,    // word
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,    // [30:0] block, [31] zero
    output logic                 m_tlast,
    output logic                 m_tuser     // [0] empty_res
);

    logic [CNT_W-1:0] in_span;
    logic             out_ready;
    w2b_res_t         res;

    w2b_span u_span (
        .data  (s_tdata),
        .avail (in_span)
    );

    w2b_slicer u_slicer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .in_span   (in_span),
        .out_ready (out_ready),
        .res       (res)
    );

    w2b_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
